// File: rtl/fcp_pkg.sv
package fcp_pkg;

   // frame delimiters
   localparam logic [7:0] START_BYTE = 8'h3C;
   localparam logic [7:0] END_BYTE   = 8'h3E;

   // channel numbers as carried in the channel byte
   localparam logic [1:0] CHAN_LIGHT = 2'd1;
   localparam logic [1:0] CHAN_PWM2  = 2'd2;
   localparam logic [1:0] CHAN_PWM3  = 2'd3;

   // highest channel number accepted
   localparam logic [7:0] CHAN_MAX   = 8'd3;
   // highest value accepted for the on/off channel
   localparam logic [7:0] LIGHT_MAX  = 8'd1;

   localparam int unsigned PWM_CHANNELS = 2;
   localparam logic [7:0]  COUNT_TOP    = 8'hFF;

   // command codes
   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // parser phases
   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_CHAN  = 2'd1,
      PH_VALUE = 2'd2,
      PH_CLOSE = 2'd3
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic out1_level;
      logic pwm2_level;
      logic pwm3_level;
      logic frame_applied;
   } rsp_type;

   // one item handed from the input register to the processing units
   typedef struct packed {
      logic byte_en;
      logic tick_en;
      logic [7:0] rx_byte;
   } step_type;

   // parser results for the word being formed
   typedef struct packed {
      logic light_on;
      logic applied;
   } parse_type;

   typedef logic [PWM_CHANNELS-1:0][7:0] duty_type;

endpackage

// File: rtl/fcp_parser.sv
module fcp_parser (
   input  logic               clock,
   input  logic               reset,
   input  fcp_pkg::step_type  step,
   output fcp_pkg::parse_type parse,
   output fcp_pkg::duty_type  duty_buf
);

   fcp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         chan_ff, chan_in;
   logic [7:0]         value_ff, value_in;
   logic               light_ff, light_in;
   fcp_pkg::duty_type  buf_ff, buf_in;
   logic               applied;
   logic               chan_ok;
   logic               value_ok;
   logic               close_ok;

   assign chan_ok  = (step.rx_byte != 8'd0) && (step.rx_byte <= fcp_pkg::CHAN_MAX);
   assign value_ok = !((chan_ff == fcp_pkg::CHAN_LIGHT) && (step.rx_byte > fcp_pkg::LIGHT_MAX));
   assign close_ok = (step.rx_byte == fcp_pkg::END_BYTE);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step.byte_en) begin
         case (phase_ff)
            fcp_pkg::PH_WAIT: begin
               if (step.rx_byte == fcp_pkg::START_BYTE) phase_in = fcp_pkg::PH_CHAN;
            end
            fcp_pkg::PH_CHAN: begin
               phase_in = chan_ok ? fcp_pkg::PH_VALUE : fcp_pkg::PH_WAIT;
            end
            fcp_pkg::PH_VALUE: begin
               phase_in = value_ok ? fcp_pkg::PH_CLOSE : fcp_pkg::PH_WAIT;
            end
            fcp_pkg::PH_CLOSE: begin
               phase_in = fcp_pkg::PH_WAIT;
            end
            default: begin
               phase_in = fcp_pkg::PH_WAIT;
            end
         endcase
      end
   end

   // frame fields, apply on close
   always_comb begin
      chan_in  = chan_ff;
      value_in = value_ff;
      light_in = light_ff;
      buf_in   = buf_ff;
      applied  = 1'b0;
      if (step.byte_en) begin
         case (phase_ff)
            fcp_pkg::PH_CHAN: begin
               if (chan_ok) chan_in = step.rx_byte[1:0];
            end
            fcp_pkg::PH_VALUE: begin
               if (value_ok) value_in = step.rx_byte;
            end
            fcp_pkg::PH_CLOSE: begin
               if (close_ok) begin
                  applied = 1'b1;
                  case (chan_ff)
                     fcp_pkg::CHAN_LIGHT: begin
                        // a value of 0 is taken but leaves the light as it is
                        if (value_ff != 8'd0) light_in = 1'b1;
                     end
                     fcp_pkg::CHAN_PWM2: begin
                        buf_in[0] = value_ff;
                     end
                     fcp_pkg::CHAN_PWM3: begin
                        buf_in[1] = value_ff;
                     end
                     default: begin
                        buf_in = buf_ff;
                     end
                  endcase
               end
            end
            default: begin
               applied = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fcp_pkg::PH_WAIT;
         chan_ff  <= 2'd0;
         value_ff <= 8'd0;
         light_ff <= 1'b1;
         buf_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         value_ff <= value_in;
         light_ff <= light_in;
         buf_ff   <= buf_in;
      end
   end

   assign parse.light_on = light_in;
   assign parse.applied  = applied;
   assign duty_buf       = buf_ff;

endmodule

// File: rtl/fcp_pwm.sv
module fcp_pwm (
   input  logic              clock,
   input  logic              reset,
   input  fcp_pkg::step_type step,
   input  fcp_pkg::duty_type duty_buf,
   output logic [fcp_pkg::PWM_CHANNELS-1:0] level
);

   logic [7:0]        count_ff, count_in;
   fcp_pkg::duty_type active_ff, active_in;
   logic              wrap;

   // counter advance; duties reload on wrap to zero
   assign wrap     = step.tick_en && (count_ff == fcp_pkg::COUNT_TOP);
   assign count_in = step.tick_en ? count_ff + 8'd1 : count_ff;

   always_comb begin
      active_in = wrap ? duty_buf : active_ff;
      for (int i = 0; i < fcp_pkg::PWM_CHANNELS; i++) begin
         level[i] = (count_in <= active_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 8'd0;
         active_ff <= '0;
      end else begin
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

endmodule

// File: rtl/framed_light_command_pwm.sv
// channel | direction | handshake                      | word
// req_    | in        | req_valid / req_ready          | fcp_pkg::req_type (cmd, rx_byte)
// rsp_    | out       | rsp_valid / rsp_ready          | fcp_pkg::rsp_type (levels, frame_applied)
//
// Every word in gives one word out: it sits in the input register, then the result
// register offers it until it is taken.
// One word per clock is sustained while rsp_ready stays high: input register, one
// pass of parser and PWM logic, then the result register.
// Synchronous active-high reset: light on, duties and counter zero, parser idle.
// A stalled result holds in its register; the input register still takes one
// more word, so req_ready drops only when both are full and rsp_ready is low.
module framed_light_command_pwm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fcp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fcp_pkg::rsp_type rsp_data
);

   logic                  in_valid_ff, in_valid_in;
   fcp_pkg::req_type      in_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   fcp_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  advance;
   logic                  req_take;
   fcp_pkg::step_type     step;
   fcp_pkg::parse_type    parse;
   fcp_pkg::duty_type     duty_buf;
   logic [fcp_pkg::PWM_CHANNELS-1:0] level;

   // pipeline control
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // word presented to the units
   assign step.byte_en = advance && (in_data_ff.cmd == fcp_pkg::CMD_BYTE);
   assign step.tick_en = advance && (in_data_ff.cmd == fcp_pkg::CMD_TICK);
   assign step.rx_byte = in_data_ff.rx_byte;

   fcp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .parse    (parse),
      .duty_buf (duty_buf)
   );

   fcp_pwm u_pwm (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .duty_buf (duty_buf),
      .level    (level)
   );

   // result word
   always_comb begin
      rsp_data_in               = rsp_data_ff;
      if (advance) begin
         rsp_data_in.out1_level    = parse.light_on;
         rsp_data_in.pwm2_level    = level[0];
         rsp_data_in.pwm3_level    = level[1];
         rsp_data_in.frame_applied = parse.applied;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/fcp_checker.sv
module fcp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input fcp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fcp_pkg::rsp_type rsp_data
);

   // a held result word stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // nothing is shown straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // the light can only be switched on, and starts on
   a_light_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out1_level)
      else $error("light output seen off");

   // with no result waiting the input side is never blocked
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // a result word on offer carries no unknown bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("unknown bits in result word");

endmodule

bind framed_light_command_pwm fcp_checker u_fcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

   // one line of the opening script: the word sent and, where it is obvious,
   // the levels it must give
   typedef struct packed {
      logic             typed;
      fcp_pkg::req_type word;
      fcp_pkg::rsp_type levels;
   } script_row_type;

   // how the result side takes words during a stretch
   typedef enum logic [1:0] {
      DRAIN_FULL,
      DRAIN_COIN,
      DRAIN_SPARSE
   } drain_mode_type;

   localparam int unsigned SCRIPT_LEN = 26;
   localparam int unsigned WORD_TARGET = 750;

   localparam fcp_pkg::rsp_type LEVELS_AT_ZERO = '{1'b1, 1'b1, 1'b1, 1'b0};
   localparam fcp_pkg::rsp_type LEVELS_PAST_ZERO = '{1'b1, 1'b0, 1'b0, 1'b0};
   localparam fcp_pkg::rsp_type LEVELS_LIGHT_OFF_FRAME = '{1'b1, 1'b0, 1'b0, 1'b1};

   localparam script_row_type OPENING_SCRIPT [SCRIPT_LEN] = '{
      // fresh from reset: count 0 against duty 0 puts both pins high
      '{1'b1, '{fcp_pkg::CMD_BYTE, 8'h00}, LEVELS_AT_ZERO},
      '{1'b1, '{fcp_pkg::CMD_BYTE, 8'hFF}, LEVELS_AT_ZERO},
      '{1'b1, '{fcp_pkg::CMD_TICK, 8'hFF}, LEVELS_PAST_ZERO},
      // bad channel numbers, low and high
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'h00}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'hFF}, '0},
      // on/off value out of range
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, {6'b0, fcp_pkg::CHAN_LIGHT}}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::LIGHT_MAX + 8'd1}, '0},
      // light-off request: frame applied, output unchanged
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, {6'b0, fcp_pkg::CHAN_LIGHT}}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'h00}, '0},
      '{1'b1, '{fcp_pkg::CMD_BYTE, fcp_pkg::END_BYTE}, LEVELS_LIGHT_OFF_FRAME},
      // missing close, the stray start byte is not a new frame
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, {6'b0, fcp_pkg::CHAN_PWM2}}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'hFF}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      // full duty on channel 2, zero duty on channel 3
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, {6'b0, fcp_pkg::CHAN_PWM2}}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'hFF}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::END_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::START_BYTE}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, {6'b0, fcp_pkg::CHAN_PWM3}}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, 8'h00}, '0},
      '{1'b0, '{fcp_pkg::CMD_BYTE, fcp_pkg::END_BYTE}, '0}
   };

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   fcp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   fcp_pkg::rsp_type rsp_data;

   // predicted state of the controller
   fcp_pkg::phase_type parse_ph = fcp_pkg::PH_WAIT;
   logic [1:0] pend_chan = '0;
   logic [7:0] pend_val = '0;
   logic       light_state = 1'b1;
   logic [7:0] duty_buf [fcp_pkg::PWM_CHANNELS] = '{default: '0};
   logic [7:0] duty_live [fcp_pkg::PWM_CHANNELS] = '{default: '0};
   logic [7:0] pwm_cnt = '0;

   fcp_pkg::rsp_type levels_due [$];
   int unsigned      fault_count = 0;
   int unsigned      burst_left = 0;

   framed_light_command_pwm DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      fault_count++;
   endtask

   // parser and PWM update for one word, giving the levels after it
   function automatic fcp_pkg::rsp_type light_pwm_step(input fcp_pkg::req_type w);
      fcp_pkg::rsp_type r;
      logic             applied;
      applied = 1'b0;
      if (fcp_pkg::cmd_type'(w.cmd) == fcp_pkg::CMD_BYTE) begin
         case (parse_ph)
            fcp_pkg::PH_WAIT: begin
               if (w.rx_byte == fcp_pkg::START_BYTE) parse_ph = fcp_pkg::PH_CHAN;
            end
            fcp_pkg::PH_CHAN: begin
               if (w.rx_byte >= {6'b0, fcp_pkg::CHAN_LIGHT} &&
                   w.rx_byte <= fcp_pkg::CHAN_MAX) begin
                  pend_chan = w.rx_byte[1:0];
                  parse_ph = fcp_pkg::PH_VALUE;
               end else begin
                  parse_ph = fcp_pkg::PH_WAIT;
               end
            end
            fcp_pkg::PH_VALUE: begin
               if (pend_chan == fcp_pkg::CHAN_LIGHT && w.rx_byte > fcp_pkg::LIGHT_MAX) begin
                  parse_ph = fcp_pkg::PH_WAIT;
               end else begin
                  pend_val = w.rx_byte;
                  parse_ph = fcp_pkg::PH_CLOSE;
               end
            end
            default: begin
               if (w.rx_byte == fcp_pkg::END_BYTE) begin
                  applied = 1'b1;
                  // the light can only be switched on
                  if (pend_chan == fcp_pkg::CHAN_LIGHT) begin
                     if (pend_val != 8'h00) light_state = 1'b1;
                  end else if (pend_chan == fcp_pkg::CHAN_PWM2) begin
                     duty_buf[0] = pend_val;
                  end else if (pend_chan == fcp_pkg::CHAN_PWM3) begin
                     duty_buf[1] = pend_val;
                  end
               end
               parse_ph = fcp_pkg::PH_WAIT;
            end
         endcase
      end else begin
         pwm_cnt = pwm_cnt + 8'd1;
         // duties move over only as the counter wraps
         if (pwm_cnt == 8'h00) begin
            duty_live[0] = duty_buf[0];
            duty_live[1] = duty_buf[1];
         end
      end
      r.out1_level = light_state;
      r.pwm2_level = (pwm_cnt <= duty_live[0]);
      r.pwm3_level = (pwm_cnt <= duty_live[1]);
      r.frame_applied = applied;
      return r;
   endfunction

   // offer one word, hold it until taken, then note what it must give;
   // the sender runs in bursts with idle gaps between them
   task automatic send_word(input fcp_pkg::req_type w, input logic typed,
                            input fcp_pkg::rsp_type typed_levels);
      fcp_pkg::rsp_type due;
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      due = light_pwm_step(w);
      levels_due.push_back(typed ? typed_levels : due);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end else begin
         burst_left--;
      end
   endtask

   function automatic fcp_pkg::req_type byte_word(input logic [7:0] b);
      fcp_pkg::req_type w;
      w.cmd = fcp_pkg::CMD_BYTE;
      w.rx_byte = b;
      return w;
   endfunction

   // stimulus: opening script, then random frames, noise and tick runs
   initial begin : feed
      fcp_pkg::req_type frame [$];
      fcp_pkg::req_type w;
      int unsigned      sent;
      int unsigned      loops;
      int unsigned      kind;
      int unsigned      n;
      logic [1:0]       chan;
      logic [7:0]       val;

      sent = 0;
      loops = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING_SCRIPT[i])
         send_word(OPENING_SCRIPT[i].word, OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].levels);

      while (sent < WORD_TARGET) begin
         loops++;
         // let everything drain once mid-run
         if (loops == 10) begin
            req_valid <= 1'b0;
            while (levels_due.size() != 0) @(posedge clock);
         end
         frame.delete();
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // well-formed frame
            chan = 2'($urandom_range(1, 3));
            val = (chan == fcp_pkg::CHAN_LIGHT) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            frame.push_back(byte_word(fcp_pkg::START_BYTE));
            frame.push_back(byte_word({6'b0, chan}));
            frame.push_back(byte_word(val));
            frame.push_back(byte_word(fcp_pkg::END_BYTE));
         end else if (kind < 55) begin
            // frame with random content in every position after the start byte
            frame.push_back(byte_word(fcp_pkg::START_BYTE));
            frame.push_back(byte_word(($urandom_range(0, 1) == 0) ?
                                      8'($urandom_range(0, 4)) : 8'($urandom)));
            frame.push_back(byte_word(($urandom_range(0, 1) == 0) ?
                                      8'($urandom_range(0, 2)) : 8'($urandom)));
            frame.push_back(byte_word(($urandom_range(0, 1) == 0) ?
                                      fcp_pkg::END_BYTE : 8'($urandom)));
         end else if (kind < 65) begin
            // line noise, not counted
            repeat ($urandom_range(1, 3))
               send_word(byte_word(8'($urandom)), 1'b0, '0);
         end else begin
            n = $urandom_range(1, 150);
            repeat (n) begin
               w.cmd = fcp_pkg::CMD_TICK;
               w.rx_byte = 8'($urandom);
               frame.push_back(w);
            end
         end
         foreach (frame[i]) begin
            // the odd tick in the middle of a frame
            if (frame[i].cmd == fcp_pkg::CMD_BYTE && $urandom_range(0, 9) == 0) begin
               w.cmd = fcp_pkg::CMD_TICK;
               w.rx_byte = 8'($urandom);
               send_word(w, 1'b0, '0);
               sent++;
            end
            send_word(frame[i], 1'b0, '0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: stretches of full, random and sparse takes, plus a long
   // hold-off now and then so the block backs up into its input
   initial begin : drain
      int unsigned    cyc;
      int unsigned    seg_left;
      int unsigned    hold_left;
      drain_mode_type mode;
      cyc = 0;
      seg_left = 0;
      hold_left = 0;
      mode = DRAIN_FULL;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 2000 == 300) hold_left = 60;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = drain_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            case (mode)
               DRAIN_FULL:  rsp_ready <= 1'b1;
               DRAIN_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
               default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // compare every word taken against the oldest outstanding prediction
   always @(posedge clock) begin : compare
      fcp_pkg::rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            due = levels_due.pop_front();
            if (rsp_data.out1_level !== due.out1_level)
               report_mismatch($sformatf("out1_level %b, wanted %b",
                                         rsp_data.out1_level, due.out1_level));
            if (rsp_data.pwm2_level !== due.pwm2_level)
               report_mismatch($sformatf("pwm2_level %b, wanted %b",
                                         rsp_data.pwm2_level, due.pwm2_level));
            if (rsp_data.pwm3_level !== due.pwm3_level)
               report_mismatch($sformatf("pwm3_level %b, wanted %b",
                                         rsp_data.pwm3_level, due.pwm3_level));
            if (rsp_data.frame_applied !== due.frame_applied)
               report_mismatch($sformatf("frame_applied %b, wanted %b",
                                         rsp_data.frame_applied, due.frame_applied));
         end
      end
   end

endmodule
